>>> rtl/assert_macros.svh
// Assertion macros used by the checker.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define RLACC_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Same, on the local clk and arst_n.
`define RLACC_ASSERT(label, prop, msg) \
	`RLACC_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

>>> rtl/rlacc_pkg.sv
// Package of the regression loss accumulator: modes, register indexes,
// queue item and sequencer types. No dependencies.
`timescale 1ns / 1ps

package rlacc_pkg;

	typedef enum logic [2:0] {
		MODE_MSE    = 3'd0,
		MODE_MWE    = 3'd1,
		MODE_UWAE   = 3'd2,
		MODE_ABSERR = 3'd3,
		MODE_CW     = 3'd4,
		MODE_CWY    = 3'd5
	} loss_mode_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PENALTY   = 2'd2;

	localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [31:0] PENALTY_RESET = 32'h0001_0000;

	// Classified sample as it waits between front and back
	typedef struct packed {
		logic [31:0] ae;
		logic [31:0] ay;
		logic        y_neg;
		logic [31:0] weight;
		logic [31:0] sigma;
		logic        dy_zero;
		logic        weighted;
		loss_mode_t  mode;
		logic        last;
	} item_t;

	// Handshake status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_MUL1,
		ST_MUL2,
		ST_DYSQ,
		ST_DIV,
		ST_ACC,
		ST_FIN_MSE,
		ST_FIN_BASE,
		ST_FIN_MUL,
		ST_OUT
	} back_state_t;

endpackage

>>> rtl/rlacc_if.sv
// Stream interfaces of the accumulator: sample channel and result channel.
// No dependencies.
`timescale 1ns / 1ps

interface rlacc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured;
	logic signed [31:0] predicted;
	logic        [31:0] sample_weight;
	logic        [31:0] uncertainty;
	logic               last;

	modport source (output valid, measured, predicted, sample_weight, uncertainty, last,
		input ready);
	modport sink (input valid, measured, predicted, sample_weight, uncertainty, last,
		output ready);
endinterface

interface rlacc_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] fitness;
	logic        [62:0] mean_sq_error;
	logic        [20:0] sample_count;
	logic               divide_fault;
	logic               saturated;

	modport source (output valid, fitness, mean_sq_error, sample_count, divide_fault,
		saturated, input ready);
	modport sink (input valid, fitness, mean_sq_error, sample_count, divide_fault,
		saturated, output ready);
endinterface

>>> rtl/regression_loss_accumulator_unit.sv
// A sample enters the queue; the back end squares its error and then, as
// its mode needs, multiplies and divides (128-step divider). The last sample
// adds the count divides and the penalty multiply before the result.
// The back end works on one sample at a time.
// Reset: arst_n clears config to defaults, sums, count, flags and the queue.
`timescale 1ns / 1ps

module regression_loss_accumulator_unit #(
	parameter int MAX_SAMPLES = 1048576,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rlacc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data,
	rlacc_in_if.sink                         in_ch,
	rlacc_out_if.source                      out_ch
);
	import rlacc_pkg::*;

	logic [2:0]  loss_mode_q;
	logic        weight_en_q;
	logic [31:0] penalty_q;
	item_t       head_item;
	logic        head_valid;
	logic        head_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_mode_q <= 3'(MODE_MSE);
			weight_en_q <= 1'b0;
			penalty_q   <= 32'd1 << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOSS_MODE: loss_mode_q <= cfg_data[2:0];
				REG_WEIGHT_EN: weight_en_q <= cfg_data[0];
				REG_PENALTY:   penalty_q   <= cfg_data;
				default:       loss_mode_q <= loss_mode_q;
			endcase
		end
	end

	rlacc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_mode     (loss_mode_q),
		.cfg_weight_en(weight_en_q),
		.in_ch        (in_ch),
		.head_item    (head_item),
		.head_valid   (head_valid),
		.head_pop     (head_pop)
	);

	rlacc_back #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.penalty   (penalty_q),
		.head_item (head_item),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.out_ch    (out_ch)
	);

endmodule

>>> rtl/rlacc_mul.sv
// 64x64 multiplier built from one 32x32 multiplier over four partial products.
// Depends on rlacc_pkg.
`timescale 1ns / 1ps

module rlacc_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             a,
	input  logic [63:0]             b,
	output rlacc_pkg::unit_status_t stat,
	output logic [127:0]            prod
);
	import rlacc_pkg::*;

	logic [2:0]   idx_q;
	logic         pv_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  pp_q;
	logic [1:0]   psh_q;
	logic [127:0] acc_q;
	logic [31:0]  a_half;
	logic [31:0]  b_half;

	// Pick operand halves for the current partial product
	assign a_half = idx_q[1] ? a[63:32] : a[31:0];
	assign b_half = idx_q[0] ? b[63:32] : b[31:0];

	// Sequence four issues; each partial product is registered in pp_q before it is added to acc_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pv_q   <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				idx_q  <= '0;
				pv_q   <= 1'b0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (idx_q != 3'd4) begin
					idx_q <= idx_q + 3'd1;
					pv_q  <= 1'b1;
				end else begin
					pv_q   <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial product and shifted accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + ({64'd0, pp_q} << {psh_q, 5'd0});
		end
		pp_q  <= a_half * b_half;
		psh_q <= {1'b0, idx_q[1]} + {1'b0, idx_q[0]};
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

>>> rtl/rlacc_div.sv
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Depends on rlacc_pkg.
`timescale 1ns / 1ps

module rlacc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [127:0]            num,
	input  logic [63:0]             den,
	output rlacc_pkg::unit_status_t stat,
	output logic [127:0]            quo
);
	import rlacc_pkg::*;

	localparam int NUM_W  = 128;
	localparam int STEP_W = $clog2(NUM_W);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [127:0]      n_q;
	logic [63:0]       d_q;
	logic [63:0]       r_q;
	logic [127:0]      q_q;
	logic [64:0]       rs;
	logic [64:0]       diff;
	logic              ge;

	// Shift in the next dividend bit and trial-subtract
	assign rs   = {r_q, n_q[NUM_W-1]};
	assign ge   = rs >= {1'b0, d_q};
	assign diff = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NUM_W-2:0], 1'b0};
			r_q <= ge ? diff[63:0] : rs[63:0];
			q_q <= {q_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = q_q;

endmodule

>>> rtl/rlacc_front.sv
// Front end: accepts samples, forms error magnitudes, classifies the mode,
// and holds them in a two-entry queue for the back end. Depends on rlacc_pkg.
`timescale 1ns / 1ps

module rlacc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       cfg_mode,
	input  logic             cfg_weight_en,
	rlacc_in_if.sink         in_ch,
	output rlacc_pkg::item_t head_item,
	output logic             head_valid,
	input  logic             head_pop
);
	import rlacc_pkg::*;

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	logic [32:0] err;
	logic [32:0] err_neg;
	loss_mode_t  mode_sel;
	item_t       new_item;

	// Error and magnitudes
	always_comb begin
		err     = {in_ch.measured[31], in_ch.measured} - {in_ch.predicted[31], in_ch.predicted};
		err_neg = ~err + 33'd1;
		mode_sel = (cfg_mode > 3'(MODE_CWY)) ? MODE_MSE : loss_mode_t'(cfg_mode);
		new_item.ae       = err[32] ? err_neg[31:0] : err[31:0];
		new_item.ay       = in_ch.measured[31] ? 32'(-in_ch.measured) : in_ch.measured;
		new_item.y_neg    = in_ch.measured[31];
		new_item.weight   = in_ch.sample_weight;
		new_item.sigma    = in_ch.uncertainty;
		new_item.dy_zero  = in_ch.uncertainty == 32'd0;
		new_item.weighted = cfg_weight_en;
		new_item.mode     = mode_sel;
		new_item.last     = in_ch.last;
	end

	assign in_ch.ready = fill_q != 2'd2;
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = fill_q != 2'd0;
	assign head_item   = mem_q[rd_ptr_q];

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (head_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !head_pop) fill_q <= fill_q + 2'd1;
			else if (!push && head_pop) fill_q <= fill_q - 2'd1;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= new_item;
	end

endmodule

>>> rtl/rlacc_back.sv
// Back end: sequences the multiplier and divider per sample, accumulates the
// sums, computes the final result and holds it in the output register.
// Depends on rlacc_pkg, rlacc_mul, rlacc_div, rlacc_out_if.
`timescale 1ns / 1ps

module rlacc_back #(
	parameter int MAX_SAMPLES = 1048576,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      penalty,
	input  rlacc_pkg::item_t head_item,
	input  logic             head_valid,
	output logic             head_pop,
	rlacc_out_if.source      out_ch
);
	import rlacc_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	back_state_t    state_q, state_d;
	item_t          it_q;
	logic [63:0]    sq_q;
	logic [127:0]   prod_q;
	logic [63:0]    dsq_q;
	logic [63:0]    ssum_q;
	logic [63:0]    msum_q;
	logic [CW-1:0]  cnt_q;
	logic           fault_q;
	logic           sat_q;
	logic [62:0]    mse_q;
	logic [63:0]    base_q;
	logic [63:0]    fit_q;

	logic           ovalid_q;
	logic [63:0]    ofit_q;
	logic [62:0]    omse_q;
	logic [20:0]    ocnt_q;
	logic           ofault_q;
	logic           osat_q;

	logic           mul_start, div_start;
	logic [63:0]    mul_a, mul_b;
	logic [127:0]   div_num;
	logic [63:0]    div_den;
	unit_status_t   mul_st, div_st;
	logic [127:0]   mul_p, div_q;

	logic           divides;
	logic           needs_mul1;
	logic           base_div;
	logic [63:0]    abs_ms;
	logic           out_load;

	logic [127:0]   term_w;
	logic           term_big;
	logic [63:0]    term_mag;
	logic           term_neg;
	logic [63:0]    term_s;
	logic [64:0]    ssum_x;
	logic [64:0]    msum_x;
	logic           msum_ovf;

	logic [127:0]   fprod;
	logic [63:0]    flimit;
	logic           fclip;
	logic [63:0]    fmag;
	logic [63:0]    fsigned;

	rlacc_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.stat  (mul_st),
		.prod  (mul_p)
	);

	rlacc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.stat  (div_st),
		.quo   (div_q)
	);

	// Mode decode of the sample in work
	always_comb begin
		divides    = it_q.mode inside {MODE_UWAE, MODE_CW, MODE_CWY};
		needs_mul1 = (it_q.mode == MODE_MSE && it_q.weighted) || it_q.mode == MODE_MWE ||
			((it_q.mode == MODE_UWAE || it_q.mode == MODE_CWY) && !it_q.dy_zero);
		base_div   = !(it_q.mode inside {MODE_UWAE, MODE_ABSERR});
		abs_ms     = msum_q[63] ? (64'd0 - msum_q) : msum_q;
		out_load   = state_q == ST_OUT && (!ovalid_q || out_ch.ready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (head_valid) state_d = ST_SQ;
			ST_SQ: begin
				if (mul_st.done) begin
					if (needs_mul1) state_d = ST_MUL1;
					else if (it_q.mode == MODE_CW && !it_q.dy_zero) state_d = ST_DYSQ;
					else state_d = ST_ACC;
				end
			end
			ST_MUL1: begin
				if (mul_st.done) begin
					if (it_q.mode == MODE_CWY) state_d = ST_MUL2;
					else if (it_q.mode == MODE_UWAE) state_d = ST_DIV;
					else state_d = ST_ACC;
				end
			end
			ST_MUL2: if (mul_st.done) state_d = ST_DYSQ;
			ST_DYSQ: if (mul_st.done) state_d = ST_DIV;
			ST_DIV: if (div_st.done) state_d = ST_ACC;
			ST_ACC: state_d = it_q.last ? ST_FIN_MSE : ST_IDLE;
			ST_FIN_MSE: if (div_st.done) state_d = ST_FIN_BASE;
			ST_FIN_BASE: if (!base_div || div_st.done) state_d = ST_FIN_MUL;
			ST_FIN_MUL: if (mul_st.done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Unit operands and starts
	always_comb begin
		head_pop  = state_q == ST_IDLE && head_valid;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		div_den   = '0;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_SQ: begin
				mul_a = {32'd0, it_q.ae};
				mul_b = {32'd0, it_q.ae};
			end
			ST_MUL1: begin
				case (it_q.mode)
					MODE_MSE: begin
						mul_a = sq_q;
						mul_b = {32'd0, it_q.weight};
					end
					MODE_MWE: begin
						mul_a = {32'd0, it_q.ae};
						mul_b = {32'd0, it_q.weight};
					end
					MODE_UWAE: begin
						mul_a = {32'd0, it_q.ay};
						mul_b = {32'd0, it_q.ae};
					end
					default: begin
						mul_a = {32'd0, it_q.ay};
						mul_b = {32'd0, it_q.ay};
					end
				endcase
			end
			ST_MUL2: begin
				mul_a = sq_q;
				mul_b = prod_q[63:0];
			end
			ST_DYSQ: begin
				mul_a = {32'd0, it_q.sigma};
				mul_b = {32'd0, it_q.sigma};
			end
			ST_DIV: begin
				case (it_q.mode)
					MODE_UWAE: begin
						div_num = prod_q << FRAC_BITS;
						div_den = {32'd0, it_q.sigma};
					end
					MODE_CW: begin
						div_num = {64'd0, sq_q} << (2 * FRAC_BITS);
						div_den = dsq_q;
					end
					default: begin
						div_num = prod_q;
						div_den = dsq_q;
					end
				endcase
			end
			ST_FIN_MSE: begin
				div_num = {64'd0, ssum_q};
				div_den = 64'(cnt_q);
			end
			ST_FIN_BASE: begin
				div_num = {64'd0, abs_ms};
				div_den = 64'(cnt_q);
			end
			ST_FIN_MUL: begin
				mul_a = base_q;
				mul_b = {32'd0, penalty};
			end
			default: begin
				mul_a = '0;
			end
		endcase
		if (state_q inside {ST_SQ, ST_MUL1, ST_MUL2, ST_DYSQ, ST_FIN_MUL})
			mul_start = !mul_st.busy && !mul_st.done;
		if (state_q inside {ST_DIV, ST_FIN_MSE} || (state_q == ST_FIN_BASE && base_div))
			div_start = !div_st.busy && !div_st.done;
	end

	// Loss term, clipped and signed
	always_comb begin
		case (it_q.mode)
			MODE_MSE:    term_w = it_q.weighted ? (prod_q >> FRAC_BITS) : {64'd0, sq_q};
			MODE_MWE:    term_w = prod_q;
			MODE_ABSERR: term_w = 128'(it_q.ae) << FRAC_BITS;
			default:     term_w = it_q.dy_zero ? 128'd0 : prod_q;
		endcase
		term_big = term_w > {64'd0, I64_MAX};
		term_mag = term_big ? I64_MAX : term_w[63:0];
		term_neg = it_q.mode == MODE_UWAE && it_q.y_neg && !it_q.dy_zero;
		term_s   = term_neg ? (64'd0 - term_mag) : term_mag;
		ssum_x   = {1'b0, ssum_q} + {1'b0, sq_q};
		msum_x   = {msum_q[63], msum_q} + {term_s[63], term_s};
		msum_ovf = msum_x[64] ^ msum_x[63];
	end

	// Fitness from the scaled base
	always_comb begin
		fprod   = mul_p >> FRAC_BITS;
		flimit  = msum_q[63] ? I64_MIN : I64_MAX;
		fclip   = fprod > {64'd0, flimit};
		fmag    = fclip ? flimit : fprod[63:0];
		fsigned = msum_q[63] ? (64'd0 - fmag) : fmag;
	end

	// Control state, sums and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ssum_q   <= '0;
			msum_q   <= '0;
			cnt_q    <= '0;
			fault_q  <= 1'b0;
			sat_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				if (ssum_x[64]) ssum_q <= '1;
				else ssum_q <= ssum_x[63:0];
				if (msum_ovf) msum_q <= term_neg ? I64_MIN : I64_MAX;
				else msum_q <= msum_x[63:0];
				if (cnt_q < CW'(MAX_SAMPLES)) cnt_q <= cnt_q + 1'b1;
				if (it_q.dy_zero && divides) fault_q <= 1'b1;
				if (term_big || ssum_x[64] || msum_ovf || cnt_q >= CW'(MAX_SAMPLES))
					sat_q <= 1'b1;
			end
			if (state_q == ST_FIN_MSE && div_st.done && (div_q[63] || div_q[127:64] != '0))
				sat_q <= 1'b1;
			if (state_q == ST_FIN_MUL && mul_st.done && fclip) sat_q <= 1'b1;
			if (out_load) begin
				ovalid_q <= 1'b1;
				ssum_q   <= '0;
				msum_q   <= '0;
				cnt_q    <= '0;
				fault_q  <= 1'b0;
				sat_q    <= 1'b0;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		if (head_pop) it_q <= head_item;
		if (state_q == ST_SQ && mul_st.done) sq_q <= mul_p[63:0];
		if ((state_q == ST_MUL1 || state_q == ST_MUL2) && mul_st.done) prod_q <= mul_p;
		if (state_q == ST_DYSQ && mul_st.done) dsq_q <= mul_p[63:0];
		if (state_q == ST_DIV && div_st.done) prod_q <= div_q;
		if (state_q == ST_FIN_MSE && div_st.done)
			mse_q <= (div_q[63] || div_q[127:64] != '0) ? I64_MAX[62:0] : div_q[62:0];
		if (state_q == ST_FIN_BASE) begin
			if (!base_div) base_q <= abs_ms;
			else if (div_st.done) base_q <= div_q[63:0];
		end
		if (state_q == ST_FIN_MUL && mul_st.done) fit_q <= fault_q ? I64_MAX : fsigned;
		if (out_load) begin
			ofit_q   <= fit_q;
			omse_q   <= mse_q;
			ocnt_q   <= 21'(cnt_q);
			ofault_q <= fault_q;
			osat_q   <= sat_q;
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.fitness       = ofit_q;
	assign out_ch.mean_sq_error = omse_q;
	assign out_ch.sample_count  = ocnt_q;
	assign out_ch.divide_fault  = ofault_q;
	assign out_ch.saturated     = osat_q;

endmodule

>>> rtl/rlacc_checker.sv
// Port-level checks of the accumulator and the bind that attaches them.
// Depends on assert_macros.svh and regression_loss_accumulator_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlacc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_fitness,
	input logic [62:0] out_mse,
	input logic        out_fault
);

	// Hold a stalled result
	`RLACC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`RLACC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_fitness) && $stable(out_mse), "stalled result changed")

	// A divide fault forces the largest fitness
	`RLACC_ASSERT(a_fault_fit, out_valid && out_fault |-> out_fitness == 64'h7FFF_FFFF_FFFF_FFFF, "fault without max fitness")

	// The queue only fills through a transfer
	`RLACC_ASSERT(a_ready_fall, $fell(in_ready) |-> $past(in_valid), "ready dropped without a transfer")

endmodule

bind regression_loss_accumulator_unit rlacc_checker u_rlacc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_fitness(out_ch.fitness),
	.out_mse    (out_ch.mean_sq_error),
	.out_fault  (out_ch.divide_fault)
);

>>> tb/regression_loss_accumulator_unit_test.sv
// Testbench of regression_loss_accumulator_unit: random and directed sample streams with a
// scoreboard that predicts every subset result. Depends on rlacc_pkg, rlacc_if.sv and DUT.
`timescale 1ns / 1ps

module regression_loss_accumulator_unit_test;
	import rlacc_pkg::*;

	localparam int MAX_SAMPLES = 1048576;
	localparam int FRAC_BITS   = 16;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [63:0] fitness;
		logic [62:0]        mse;
		logic [20:0]        count;
		logic               fault;
		logic               sat;
	} loss_result_t;

	// Loss predictor and queue of expected subset results
	class loss_scoreboard;
		logic [2:0]  loss_mode;
		logic        weight_en;
		logic [31:0] penalty;
		logic [63:0] sq_sum;
		logic signed [63:0] term_sum;
		int unsigned samples;
		logic        div_fault;
		logic        clipped;
		loss_result_t pending[$];
		int errors;

		function new();
			loss_mode = MODE_MSE;
			weight_en = 1'b0;
			penalty = PENALTY_RESET;
			sq_sum = '0;
			term_sum = '0;
			samples = 0;
			div_fault = 1'b0;
			clipped = 1'b0;
			errors = 0;
		endfunction

		function logic [63:0] clip(logic [127:0] x, logic [63:0] limit);
			if (x > {64'd0, limit}) begin
				clipped = 1'b1;
				return limit;
			end
			return x[63:0];
		endfunction

		function void note_sample(logic [31:0] m, logic [31:0] pr, logic [31:0] w,
				logic [31:0] dy, logic last);
			logic signed [63:0] y, p, e, term;
			logic [63:0] ae, ay, sq, mag, cnt, mse, base_mag, fit;
			logic [64:0] usum;
			logic signed [65:0] ssum;
			logic [127:0] wide;
			logic [2:0] md;
			logic neg, base_neg;
			loss_result_t r;
			y = {{32{m[31]}}, m};
			p = {{32{pr[31]}}, pr};
			e = y - p;
			ae = (e < 0) ? -e : e;
			ay = (y < 0) ? -y : y;
			sq = ae * ae;
			mag = '0;
			neg = 1'b0;
			md = (loss_mode > MODE_CWY) ? MODE_MSE : loss_mode;
			// Form the per-sample loss term magnitude
			if (md == MODE_MSE) begin
				if (weight_en) begin
					wide = ({64'd0, sq} * {96'd0, w}) >> FRAC_BITS;
					mag = clip(wide, I64_MAX);
				end else begin
					mag = clip({64'd0, sq}, I64_MAX);
				end
			end else if (md == MODE_MWE) begin
				mag = clip({64'd0, ae} * {96'd0, w}, I64_MAX);
			end else if (md == MODE_ABSERR) begin
				mag = ae << FRAC_BITS;
			end else if (dy == 0) begin
				div_fault = 1'b1;
			end else if (md == MODE_UWAE) begin
				wide = (({64'd0, ay} * {64'd0, ae}) << FRAC_BITS) / {96'd0, dy};
				mag = clip(wide, I64_MAX);
				neg = y < 0;
			end else begin
				if (md == MODE_CW)
					wide = {64'd0, sq} << (2 * FRAC_BITS);
				else
					wide = {64'd0, sq} * {64'd0, ay * ay};
				mag = clip(wide / {64'd0, {32'd0, dy} * {32'd0, dy}}, I64_MAX);
			end
			// Accumulate with saturation
			usum = {1'b0, sq_sum} + {1'b0, sq};
			if (usum[64]) begin
				sq_sum = '1;
				clipped = 1'b1;
			end else begin
				sq_sum = usum[63:0];
			end
			term = neg ? -$signed(mag) : $signed(mag);
			ssum = {{2{term_sum[63]}}, term_sum} + {{2{term[63]}}, term};
			if (ssum > $signed({2'b00, I64_MAX})) begin
				term_sum = I64_MAX;
				clipped = 1'b1;
			end else if (ssum < $signed({2'b11, I64_MIN})) begin
				term_sum = I64_MIN;
				clipped = 1'b1;
			end else begin
				term_sum = ssum[63:0];
			end
			if (samples < MAX_SAMPLES) samples++;
			else clipped = 1'b1;
			if (!last) return;
			// Close the subset
			cnt = samples;
			mse = sq_sum / cnt;
			if (mse > I64_MAX) begin
				mse = I64_MAX;
				clipped = 1'b1;
			end
			base_neg = term_sum < 0;
			base_mag = base_neg ? -term_sum : term_sum;
			if (md != MODE_UWAE && md != MODE_ABSERR) base_mag = base_mag / cnt;
			wide = ({64'd0, base_mag} * {96'd0, penalty}) >> FRAC_BITS;
			fit = clip(wide, base_neg ? I64_MIN : I64_MAX);
			if (base_neg) fit = -fit;
			if (div_fault) fit = I64_MAX;
			r.fitness = fit;
			r.mse = mse[62:0];
			r.count = cnt[20:0];
			r.fault = div_fault;
			r.sat = clipped;
			pending = {pending, r};
			sq_sum = '0;
			term_sum = '0;
			samples = 0;
			div_fault = 1'b0;
			clipped = 1'b0;
		endfunction

		function void check_result(loss_result_t got);
			loss_result_t want;
			if (pending.size() == 0) begin
				$error("result with no expected subset: fitness %h", got.fitness);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.fitness !== want.fitness) begin
				$error("fitness expected %h actual %h", want.fitness, got.fitness);
				errors++;
			end
			if (got.mse !== want.mse) begin
				$error("mean_sq_error expected %h actual %h", want.mse, got.mse);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("sample_count expected %0d actual %0d", want.count, got.count);
				errors++;
			end
			if (got.fault !== want.fault) begin
				$error("divide_fault expected %b actual %b", want.fault, got.fault);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$error("saturated expected %b actual %b", want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	rlacc_in_if in_ch ();
	rlacc_out_if out_ch ();
	loss_scoreboard sb;
	longint cycles;
	int sent_random;
	bit no_gaps;

	regression_loss_accumulator_unit #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Field value: full range, small Q16.16 values or extremes
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// Count cycles and stop on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stall the result channel at random
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		loss_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.fitness = out_ch.fitness;
			got.mse = out_ch.mean_sq_error;
			got.count = out_ch.sample_count;
			got.fault = out_ch.divide_fault;
			got.sat = out_ch.saturated;
			sb.check_result(got);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LOSS_MODE) sb.loss_mode = data[2:0];
		else if (idx == REG_WEIGHT_EN) sb.weight_en = data[0];
		else if (idx == REG_PENALTY) sb.penalty = data;
	endtask

	// Drive one sample and hold it until the transfer
	task automatic send_sample(logic [31:0] m, logic [31:0] p, logic [31:0] w,
			logic [31:0] dy, logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.measured <= m;
		in_ch.predicted <= p;
		in_ch.sample_weight <= w;
		in_ch.uncertainty <= dy;
		in_ch.last <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_sample(m, p, w, dy, last);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_subset();
		int len;
		logic [31:0] dy;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			dy = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_word();
			send_sample(pick_word(), pick_word(), pick_word(), dy, i == len - 1);
			sent_random++;
		end
	endtask

	initial begin
		logic [31:0] pen;
		int phase;
		sb = new();
		cycles = 0;
		sent_random = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.measured = '0;
		in_ch.predicted = '0;
		in_ch.sample_weight = '0;
		in_ch.uncertainty = '0;
		in_ch.last = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset defaults, then each mode with extreme errors and zero sigma
		send_sample(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		settle();
		for (int md = MODE_MSE; md <= MODE_CWY; md++) begin
			write_reg(REG_LOSS_MODE, md);
			write_reg(REG_WEIGHT_EN, md == MODE_MSE);
			write_reg(REG_PENALTY, 32'hFFFF_FFFF);
			send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 1'b0);
			send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
			send_sample(32'h8000_0000, 32'h0000_0000, 32'd0, 32'd0, 1'b1);
			settle();
		end
		write_reg(REG_PENALTY, 32'd0);
		write_reg(2'd3, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_0001, 1'b1);
		settle();

		// Random phases over all settings, unused modes included
		phase = 0;
		while (sent_random < 1450) begin
			case ($urandom_range(0, 4))
				0: pen = 32'd0;
				1: pen = PENALTY_RESET;
				2: pen = 32'hFFFF_FFFF;
				3: pen = $urandom_range(0, 32'h0004_0000);
				default: pen = $urandom;
			endcase
			write_reg(REG_LOSS_MODE, {$urandom} & 32'hFFFF_FFF8 | (phase % 8));
			write_reg(REG_WEIGHT_EN, $urandom);
			write_reg(REG_PENALTY, pen);
			if ($urandom_range(0, 3) == 0) write_reg(2'd3, $urandom);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (6) random_subset();
			settle();
			phase++;
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rlacc_pkg.sv
rtl/rlacc_if.sv
rtl/rlacc_mul.sv
rtl/rlacc_div.sv
rtl/rlacc_front.sv
rtl/rlacc_back.sv
rtl/regression_loss_accumulator_unit.sv
rtl/rlacc_checker.sv
tb/regression_loss_accumulator_unit_test.sv
